// ===== rtl/core/scl_pkg.sv =====
// Shared types, character codes and command word tables for the serial
// command line parser. Every module of the block but scl_ram imports this package.
package scl_pkg;

  localparam int MAX_LEN = 30;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CHAR_W  = 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Received byte codes.
  localparam logic [7:0] KEY_SPACE = 8'd32;
  localparam logic [7:0] KEY_BS    = 8'h7F;
  localparam logic [7:0] KEY_ENTER = 8'h0D;
  localparam logic [7:0] KEY_LF    = 8'd10;
  localparam logic [7:0] KEY_LOW   = 8'd48;
  localparam logic [7:0] KEY_HIGH  = 8'd123;

  // Stored character codes.
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'd57;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOVAL = 2'd1;
  localparam logic [1:0] ST_NAN   = 2'd2;

  localparam int WORD1_LEN   = 19;
  localparam int WORD2_LEN   = 11;
  localparam int W1_IDX_W    = $clog2(WORD1_LEN);
  localparam int W2_IDX_W    = $clog2(WORD2_LEN);
  localparam logic [8*WORD1_LEN-1:0] WORD1_STR = {"flash_print", "_segment"};
  localparam logic [8*WORD2_LEN-1:0] WORD2_STR = {"flash", "_check"};

  typedef enum logic {
    OP_ECHO  = 1'b0,
    OP_ENTER = 1'b1
  } op_kind_t;

  // One word handed from the front to the back.
  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
  } op_t;

  function automatic logic [CHAR_W-1:0] word1_at(input logic [W1_IDX_W-1:0] i);
    return WORD1_STR[8*(WORD1_LEN-1-int'(i)) +: CHAR_W];
  endfunction

  function automatic logic [CHAR_W-1:0] word2_at(input logic [W2_IDX_W-1:0] i);
    return WORD2_STR[8*(WORD2_LEN-1-int'(i)) +: CHAR_W];
  endfunction

endpackage

// ===== rtl/core/scl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/scl_front.sv =====
// Front end: accepts received bytes, classifies them, keeps the line length
// and writes the line store. Uses scl_pkg.
module scl_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                in_rx_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output scl_pkg::op_t              q_op,
  input  logic                      walk_done,
  output logic                      ram_we,
  output logic [scl_pkg::IDX_W-1:0] ram_waddr,
  output logic [scl_pkg::CHAR_W-1:0] ram_wdata
);
  import scl_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pending_r, pending_nxt;
  logic             accept, is_print, do_store, do_bs, do_enter;

  // While a finished line is being walked, the store must not change.
  assign full   = q_full || pending_r;
  assign accept = push && !full;

  always_comb begin
    is_print = (in_rx_byte == KEY_SPACE) ||
               ((in_rx_byte >= KEY_LOW) && (in_rx_byte <= KEY_HIGH));
    do_store = accept && is_print && (count_r != CNT_W'(MAX_LEN));
    do_bs    = accept && (in_rx_byte == KEY_BS) && (count_r != '0);
    do_enter = accept && (in_rx_byte == KEY_ENTER);

    count_nxt = count_r;
    if (do_store) begin
      count_nxt = count_r + 1'b1;
    end else if (do_bs) begin
      count_nxt = count_r - 1'b1;
    end else if (do_enter) begin
      count_nxt = '0;
    end

    pending_nxt = pending_r;
    if (do_enter) begin
      pending_nxt = 1'b1;
    end else if (walk_done) begin
      pending_nxt = 1'b0;
    end

    q_push      = do_store || do_bs || do_enter;
    q_op.kind   = do_enter ? OP_ENTER : OP_ECHO;
    q_op.data   = in_rx_byte;
    q_op.len    = count_r;

    ram_we    = do_store;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = in_rx_byte[CHAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pending_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ===== rtl/core/scl_op_fifo.sv =====
// Short queue of classified words between the front and the back end.
// Uses scl_pkg for the word type and depth.
module scl_op_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_en,
  input  scl_pkg::op_t push_op,
  output logic         q_full,
  input  logic         pop_en,
  output logic         q_valid,
  output scl_pkg::op_t pop_op
);
  import scl_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign pop_op  = slot_r[rptr_r];

  always_comb begin
    do_push  = push_en && !q_full;
    do_pop   = pop_en && q_valid;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/scl_back.sv =====
// Back end: carries out queued words, walks the line store on enter to
// match the command word and convert the value, and holds the result word.
// Uses scl_pkg.
module scl_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  scl_pkg::op_t               q_op,
  output logic                       q_pop,
  output logic                       walk_done,
  output logic                       ram_re,
  output logic [scl_pkg::IDX_W-1:0]  ram_raddr,
  input  logic [scl_pkg::CHAR_W-1:0] ram_rdata,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_echo_byte,
  output logic                       out_line_done,
  output logic [1:0]                 out_command_id,
  output logic [31:0]                out_number_value,
  output logic [1:0]                 out_value_status,
  output logic                       out_last
);
  import scl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, len_r, len_nxt, idx_inc;
  logic             seen_r, seen_nxt, m1_r, m1_nxt, m2_r, m2_nxt;
  logic [31:0]      value_r, value_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      idx32, len32;
  logic             hit1, hit2, is_digit, out_free;

  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       oecho_r, oecho_nxt;
  logic             odone_r, odone_nxt, olast_r, olast_nxt;
  logic [1:0]       ocmd_r, ocmd_nxt, ostat_r, ostat_nxt;
  logic [31:0]      oval_r, oval_nxt;

  assign empty            = !ovalid_r;
  assign out_echo_byte    = oecho_r;
  assign out_line_done    = odone_r;
  assign out_command_id   = ocmd_r;
  assign out_number_value = oval_r;
  assign out_value_status = ostat_r;
  assign out_last         = olast_r;

  always_comb begin
    out_free  = !ovalid_r || pop;
    idx32     = 32'(idx_r);
    len32     = 32'(len_r);
    idx_inc   = CNT_W'(idx_r + 1'b1);
    is_digit  = (ram_rdata >= CH_ZERO) && (ram_rdata <= CH_NINE);
    // Without a space the whole line is the word, so its length is checked here.
    hit1      = seen_r ? m1_r : (m1_r && (len32 == WORD1_LEN));
    hit2      = seen_r ? m2_r : (m2_r && (len32 == WORD2_LEN));

    state_nxt  = state_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    m1_nxt     = m1_r;
    m2_nxt     = m2_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    q_pop      = 1'b0;
    walk_done  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[IDX_W-1:0];

    ovalid_nxt = ovalid_r && !pop;
    oecho_nxt  = oecho_r;
    odone_nxt  = odone_r;
    ocmd_nxt   = ocmd_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop      = 1'b1;
          ovalid_nxt = 1'b1;
          oecho_nxt  = q_op.data;
          odone_nxt  = 1'b0;
          ocmd_nxt   = CMD_NONE;
          oval_nxt   = '0;
          ostat_nxt  = ST_OK;
          olast_nxt  = 1'b1;
          if (q_op.kind == OP_ENTER) begin
            oecho_nxt  = KEY_ENTER;
            olast_nxt  = 1'b0;
            len_nxt    = q_op.len;
            idx_nxt    = '0;
            seen_nxt   = 1'b0;
            m1_nxt     = 1'b1;
            m2_nxt     = 1'b1;
            value_nxt  = '0;
            status_nxt = ST_NOVAL;
            state_nxt  = (q_op.len == '0) ? S_DONE : S_READ;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!seen_r) begin
          if (ram_rdata == CH_SPACE) begin
            seen_nxt   = 1'b1;
            status_nxt = ST_OK;
            m1_nxt     = m1_r && (idx32 == WORD1_LEN);
            m2_nxt     = m2_r && (idx32 == WORD2_LEN);
          end else begin
            m1_nxt = m1_r && (idx32 < WORD1_LEN) &&
                     (ram_rdata == word1_at(idx32[W1_IDX_W-1:0]));
            m2_nxt = m2_r && (idx32 < WORD2_LEN) &&
                     (ram_rdata == word2_at(idx32[W2_IDX_W-1:0]));
          end
        end else if (status_r == ST_OK) begin
          if (is_digit) begin
            value_nxt = (value_r << 3) + (value_r << 1) +
                        32'(4'(ram_rdata - CH_ZERO));
          end else begin
            status_nxt = ST_NAN;
            value_nxt  = '0;
          end
        end
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == len_r) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oecho_nxt  = KEY_LF;
          odone_nxt  = 1'b1;
          ocmd_nxt   = hit1 ? CMD_SEGMENT : (hit2 ? CMD_CHECK : CMD_NONE);
          oval_nxt   = value_r;
          ostat_nxt  = status_r;
          olast_nxt  = 1'b1;
          walk_done  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    seen_r   <= seen_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    oecho_r  <= oecho_nxt;
    odone_r  <= odone_nxt;
    ocmd_r   <= ocmd_nxt;
    oval_r   <= oval_nxt;
    ostat_r  <= ostat_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

// ===== rtl/core/serial_command_line_parser.sv =====
// Serial command line parser top level: front end, word queue, back end, line store.
// A taken byte passes the word queue into the result register as its echo word;
// on enter the CR word follows, and the LF report once the line is walked.
// Throughput: one echoed byte per cycle while results are popped; after enter no
// byte is taken until the LF report is loaded, as the back end reads the line store.
// Reset (rst_n low, synchronous) empties the line, the queue and the result register.
module serial_command_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_echo_byte,
  output logic        out_line_done,
  output logic [1:0]  out_command_id,
  output logic [31:0] out_number_value,
  output logic [1:0]  out_value_status,
  output logic        out_last
);
  import scl_pkg::*;

  logic              q_full, q_push, q_valid, q_pop, walk_done;
  op_t               q_in_op, q_out_op;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  scl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (q_in_op),
    .walk_done  (walk_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  scl_op_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (q_push),
    .push_op (q_in_op),
    .q_full  (q_full),
    .pop_en  (q_pop),
    .q_valid (q_valid),
    .pop_op  (q_out_op)
  );

  scl_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_op             (q_out_op),
    .q_pop            (q_pop),
    .walk_done        (walk_done),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .empty            (empty),
    .pop              (pop),
    .out_echo_byte    (out_echo_byte),
    .out_line_done    (out_line_done),
    .out_command_id   (out_command_id),
    .out_number_value (out_number_value),
    .out_value_status (out_value_status),
    .out_last         (out_last)
  );

`ifndef ASSERT_OFF
  // The front end must never push into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("word pushed into full queue");

  // The line store is never written while the back end walks it.
  a_no_write_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re) else $error("line store written during walk");

  // A line report always rides on the final LF word.
  a_done_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_line_done) |-> (out_echo_byte == KEY_LF) && out_last)
    else $error("line report on wrong word");

  // Words that close no line carry no report.
  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_line_done) |-> (out_command_id == CMD_NONE) &&
      (out_number_value == 32'd0) && (out_value_status == ST_OK))
    else $error("report fields set on echo word");
`endif

endmodule

// ===== tb/scl_checker.sv =====
// Checker for the serial command line parser: watches both queue channels,
// keeps its own copy of the line being edited and compares every result word.
// Depends on scl_pkg for the character codes, command ids and status codes.
module scl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_echo_byte,
  input  logic        out_line_done,
  input  logic [1:0]  out_command_id,
  input  logic [31:0] out_number_value,
  input  logic [1:0]  out_value_status,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          answered_bytes
);
  import scl_pkg::*;

  typedef struct packed {
    logic [7:0]  echo;
    logic        done;
    logic [1:0]  cmd;
    logic [31:0] val;
    logic [1:0]  status;
    logic        last;
  } line_word_t;

  line_word_t         awaited_words[$];
  logic [CHAR_W-1:0]  line_chars[MAX_LEN];
  int                 line_len;

  // True when the text before the first space, or the whole line, equals w.
  function automatic bit head_is(input string w);
    int i;
    i = 0;
    while (i < line_len && line_chars[i] != CH_SPACE) begin
      if (i >= w.len() || w[i] != {1'b0, line_chars[i]}) return 1'b0;
      i++;
    end
    return i == w.len();
  endfunction

  task automatic predict_words(input logic [7:0] b);
    line_word_t w;
    int i;
    w = '0;
    if ((b == KEY_SPACE || (b >= KEY_LOW && b <= KEY_HIGH)) && line_len < MAX_LEN) begin
      line_chars[line_len] = b[CHAR_W-1:0];
      line_len++;
      w.echo = b;
      w.last = 1'b1;
      awaited_words.push_back(w);
      answered_bytes++;
    end else if (b == KEY_BS && line_len > 0) begin
      line_len--;
      w.echo = b;
      w.last = 1'b1;
      awaited_words.push_back(w);
      answered_bytes++;
    end else if (b == KEY_ENTER) begin
      w.echo = KEY_ENTER;
      awaited_words.push_back(w);
      w.echo = KEY_LF;
      w.done = 1'b1;
      w.last = 1'b1;
      if (head_is({"flash_print", "_segment"})) w.cmd = CMD_SEGMENT;
      else if (head_is({"flash", "_check"})) w.cmd = CMD_CHECK;
      else w.cmd = CMD_NONE;
      w.status = ST_NOVAL;
      i = 0;
      while (i < line_len && line_chars[i] != CH_SPACE) i++;
      if (i < line_len) begin
        w.status = ST_OK;
        for (i = i + 1; i < line_len; i++) begin
          if (line_chars[i] < CH_ZERO || line_chars[i] > CH_NINE) begin
            w.status = ST_NAN;
            w.val = '0;
            break;
          end
          w.val = w.val * 32'd10 + {25'd0, line_chars[i] - CH_ZERO};
        end
      end
      awaited_words.push_back(w);
      answered_bytes++;
      line_len = 0;
    end
  endtask

  task automatic compare_word();
    line_word_t seen, want;
    seen = {out_echo_byte, out_line_done, out_command_id, out_number_value,
            out_value_status, out_last};
    if (awaited_words.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: echo=%02h done=%0b cmd=%0d val=%0d st=%0d last=%0b",
                 seen.echo, seen.done, seen.cmd, seen.val, seen.status, seen.last);
    end else begin
      want = awaited_words.pop_front();
      if (seen !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want echo=%02h done=%0b cmd=%0d val=%0d st=%0d last=%0b, %s",
                   want.echo, want.done, want.cmd, want.val, want.status, want.last,
                   $sformatf("got echo=%02h done=%0b cmd=%0d val=%0d st=%0d last=%0b",
                             seen.echo, seen.done, seen.cmd, seen.val, seen.status,
                             seen.last));
      end
    end
  endtask

  // Pre-edge values are seen here, so each handshake is judged as the block saw it.
  always @(posedge clk) begin
    if (!rst_n) begin
      line_len = 0;
      awaited_words.delete();
    end else begin
      if (pop === 1'b1 && empty === 1'b0) compare_word();
      if (push === 1'b1 && full === 1'b0) predict_words(in_rx_byte);
    end
    pending = awaited_words.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the serial command line parser: clock, reset, byte stimulus,
// result draining with random stalls, watchdog and verdict.
// Depends on scl_pkg, serial_command_line_parser and scl_checker.
module tb;
  import scl_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TARGET_BYTES = 1600;
  localparam int CALM_AFTER = 1400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        full, empty;
  logic [7:0]  out_echo_byte;
  logic        out_line_done;
  logic [1:0]  out_command_id;
  logic [31:0] out_number_value;
  logic [1:0]  out_value_status;
  logic        out_last;

  int          errors, pending, answered;
  bit          calm = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_hold = 0;
  int          rx_quiet = 0;
  int          stall = 0;
  logic [7:0]  line_q[$];

  always #10 clk = ~clk;

  serial_command_line_parser dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_rx_byte(in_rx_byte),
    .empty(empty), .pop(pop), .out_echo_byte(out_echo_byte),
    .out_line_done(out_line_done), .out_command_id(out_command_id),
    .out_number_value(out_number_value), .out_value_status(out_value_status),
    .out_last(out_last)
  );

  scl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_rx_byte(in_rx_byte),
    .empty(empty), .pop(pop), .out_echo_byte(out_echo_byte),
    .out_line_done(out_line_done), .out_command_id(out_command_id),
    .out_number_value(out_number_value), .out_value_status(out_value_status),
    .out_last(out_last), .errors(errors), .pending(pending),
    .answered_bytes(answered)
  );

  // Result side: random stall bursts, with occasional long stretches of steady popping.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      pop <= 1'b0;
      rx_hold--;
    end else if (rx_quiet > 0 || calm) begin
      pop <= 1'b1;
      if (rx_quiet > 0) rx_quiet--;
    end else if ($urandom_range(0, 9) == 0) begin
      pop <= 1'b0;
      rx_hold = $urandom_range(1, 10) - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 40) == 0) rx_quiet = $urandom_range(20, 100);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Returns right after the edge that takes the word; push stays high until the
  // next falling edge decides what comes next.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic hold_and_drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_printable();
    case ($urandom_range(0, 3))
      0:       return KEY_SPACE;
      1:       return 8'($urandom_range(48, 57));
      default: return 8'($urandom_range(48, 123));
    endcase
  endfunction

  function automatic logic [7:0] non_digit();
    if ($urandom_range(0, 3) == 0) return KEY_SPACE;
    return 8'($urandom_range(58, 123));
  endfunction

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(8'($urandom_range(48, 57)));
  endtask

  task automatic add_value();
    case ($urandom_range(0, 6))
      0: ;
      1: line_q.push_back(KEY_SPACE);
      2: begin
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(1, 5));
      end
      3: begin
        // Eight to twelve digits; the longest of them wrap past 32 bits.
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(8, 12));
      end
      4: begin
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(0, 3));
        line_q.push_back(non_digit());
        add_digits($urandom_range(0, 2));
      end
      5: begin
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(1, 3));
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(0, 3));
      end
      default: begin
        line_q.push_back(KEY_SPACE);
        add_digits($urandom_range(1, 9));
      end
    endcase
  endtask

  function automatic string command_word();
    string w;
    int k;
    if ($urandom_range(0, 1)) w = {"flash_print", "_segment"};
    else w = {"flash", "_check"};
    case ($urandom_range(0, 5))
      0: w = w.substr(0, $urandom_range(0, w.len() - 2));
      1: w = {w, "_"};
      2: begin
        k = $urandom_range(0, w.len() - 1);
        w.putc(k, 8'($urandom_range(97, 122)));
      end
      default: ;
    endcase
    return w;
  endfunction

  // Sends the built line, now and then typing a stray character and erasing it.
  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) begin
      if ($urandom_range(0, 14) == 0) begin
        send_byte(any_printable());
        send_byte(KEY_BS);
      end
      send_byte(line_q[i]);
    end
    line_q.delete();
  endtask

  task automatic random_line();
    int kind;
    bit noise;
    noise = 1'b0;
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(KEY_BS);
    kind = $urandom_range(0, 19);
    if (kind <= 9) begin
      add_text(command_word());
      add_value();
    end else if (kind <= 12) begin
      repeat ($urandom_range(0, 12)) line_q.push_back(any_printable());
    end else if (kind <= 14) begin
      repeat ($urandom_range(29, 40)) line_q.push_back(any_printable());
    end else if (kind == 15) begin
      line_q.push_back(KEY_SPACE);
      add_digits($urandom_range(0, 10));
    end else if (kind <= 17) begin
      noise = 1'b1;
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Fills the line to its limit, and runs into it when more than ten digits are drawn.
      add_text({"flash_print", "_segment"});
      line_q.push_back(KEY_SPACE);
      add_digits($urandom_range(10, 13));
    end
    if (!noise && $urandom_range(0, 19) != 0) line_q.push_back(KEY_ENTER);
    send_line();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    line_q = {KEY_BS, KEY_ENTER, 8'h00, 8'hFF, 8'd47, 8'd124, KEY_LOW, KEY_HIGH,
              KEY_SPACE, 8'd57, KEY_BS, KEY_ENTER};
    add_text({"flash", "_check 9"});
    line_q.push_back(KEY_ENTER);
    while (line_q.size() != 0) send_byte(line_q.pop_front());
    hold_and_drain();

    while (answered < TARGET_BYTES) begin
      calm = (answered >= CALM_AFTER);
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 10;
        default: tx_idle_pct = 35;
      endcase
      random_line();
      if ($urandom_range(0, 24) == 0) hold_and_drain();
    end

    hold_and_drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/scl_pkg.sv
rtl/core/scl_ram.sv
rtl/core/scl_front.sv
rtl/core/scl_op_fifo.sv
rtl/core/scl_back.sv
rtl/core/serial_command_line_parser.sv
tb/scl_checker.sv
tb/tb.sv
